FILE: src/assert_macros.svh
// ----------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the classify cache.
// ----------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CCC_ASSERT(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define CCC_ASSERT_NEVER(label, clk_s, rstn_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`endif

FILE: src/ccc_pkg.sv
// ----------------------------------------------------------------
// Congestion classify cache package
// Shared types, codes and defaults.
// ----------------------------------------------------------------
package ccc_pkg;

  localparam int unsigned LINES_DEF      = 65536;
  localparam int unsigned SPEED_BITS_DEF = 8;

  localparam int ENTRY_BITS    = 2;
  localparam int REGION_BITS   = 20;
  localparam int LINE_BITS     = 16;
  localparam int CLASS_BITS    = 4;
  localparam int LAYER_BITS    = 2;
  localparam int MIN_BITS      = 8;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [ENTRY_BITS-1:0] entry_t;

  localparam entry_t ENTRY_UNKNOWN   = 2'h0;
  localparam entry_t ENTRY_NORMAL    = 2'h1;
  localparam entry_t ENTRY_CONGESTED = 2'h2;

  localparam logic [MIN_BITS-1:0]   MIN_SPEED_RESET = 8'd15;
  localparam logic [CLASS_BITS-1:0] MAX_CLASS_RESET = 4'd3;
  localparam logic [LAYER_BITS-1:0] LAYER_MAX       = 2'd1;

  localparam logic [1:0] REG_DISPLAY   = 2'd0;
  localparam logic [1:0] REG_MIN_SPEED = 2'd1;
  localparam logic [1:0] REG_MAX_CLASS = 2'd2;

  typedef struct packed {
    logic                  display_enabled;
    logic [MIN_BITS-1:0]   min_average_speed;
    logic [CLASS_BITS-1:0] max_road_class;
  } cfg_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_INDEX,
    S_LOOK,
    S_DONE
  } state_t;

endpackage

FILE: src/ccc_regs.sv
// ----------------------------------------------------------------
// Configuration registers
// APB write/read of display enable, minimum speed and class limit.
// ----------------------------------------------------------------
module ccc_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ccc_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [ccc_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [ccc_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready,
  output ccc_pkg::cfg_t                        cfg
);

  ccc_pkg::cfg_t cfg_r;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_enabled   <= 1'b0;
      cfg_r.min_average_speed <= ccc_pkg::MIN_SPEED_RESET;
      cfg_r.max_road_class    <= ccc_pkg::MAX_CLASS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        ccc_pkg::REG_DISPLAY:   cfg_r.display_enabled   <= pwdata[0];
        ccc_pkg::REG_MIN_SPEED: cfg_r.min_average_speed <= pwdata[ccc_pkg::MIN_BITS-1:0];
        ccc_pkg::REG_MAX_CLASS: cfg_r.max_road_class    <= pwdata[ccc_pkg::CLASS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ccc_pkg::REG_DISPLAY:   prdata = ccc_pkg::CFG_DATA_BITS'(cfg_r.display_enabled);
      ccc_pkg::REG_MIN_SPEED: prdata = ccc_pkg::CFG_DATA_BITS'(cfg_r.min_average_speed);
      ccc_pkg::REG_MAX_CLASS: prdata = ccc_pkg::CFG_DATA_BITS'(cfg_r.max_road_class);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: src/ccc_store.sv
// ----------------------------------------------------------------
// Line state store
// Single-port-write, registered-read memory of 2-bit line verdicts.
// ----------------------------------------------------------------
module ccc_store #(
  parameter int unsigned LINES = ccc_pkg::LINES_DEF,
  parameter int          AW    = $clog2(LINES)
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output ccc_pkg::entry_t        rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  ccc_pkg::entry_t        wr_data
);

  ccc_pkg::entry_t mem_r [LINES];
  ccc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/ccc_judge.sv
// ----------------------------------------------------------------
// Speed judge
// Forward then reverse direction verdict, normal when undecided.
// ----------------------------------------------------------------
module ccc_judge #(
  parameter int unsigned SPEED_BITS = ccc_pkg::SPEED_BITS_DEF
) (
  input  ccc_pkg::cfg_t           cfg,
  input  logic [SPEED_BITS-1:0]   speed_forward,
  input  logic [SPEED_BITS-1:0]   average_forward,
  input  logic [SPEED_BITS-1:0]   speed_reverse,
  input  logic [SPEED_BITS-1:0]   average_reverse,
  output ccc_pkg::entry_t         verdict
);

  localparam int CW = (SPEED_BITS > ccc_pkg::MIN_BITS) ? SPEED_BITS : ccc_pkg::MIN_BITS;
  localparam int PW = SPEED_BITS + 2;

  // speed < floor(2*avg/3)  <=>  3*speed + 3 <= 2*avg
  function automatic ccc_pkg::entry_t judge_dir(
    input logic [SPEED_BITS-1:0]        spd,
    input logic [SPEED_BITS-1:0]        avg,
    input logic [ccc_pkg::MIN_BITS-1:0] min_spd
  );
    logic [PW-1:0]   lhs;
    logic [PW-1:0]   rhs;
    ccc_pkg::entry_t res;
    lhs = PW'(spd) + PW'({spd, 1'b0}) + PW'(3);
    rhs = PW'({avg, 1'b0});
    priority if (spd == '0) begin
      res = ccc_pkg::ENTRY_UNKNOWN;
    end else if (CW'(avg) < CW'(min_spd)) begin
      res = ccc_pkg::ENTRY_NORMAL;
    end else if (lhs <= rhs) begin
      res = ccc_pkg::ENTRY_CONGESTED;
    end else begin
      res = ccc_pkg::ENTRY_UNKNOWN;
    end
    return res;
  endfunction

  ccc_pkg::entry_t v_fwd;
  ccc_pkg::entry_t v_rev;

  always_comb begin
    v_fwd = judge_dir(speed_forward, average_forward, cfg.min_average_speed);
    v_rev = judge_dir(speed_reverse, average_reverse, cfg.min_average_speed);
    priority if (v_fwd != ccc_pkg::ENTRY_UNKNOWN) begin
      verdict = v_fwd;
    end else if (v_rev != ccc_pkg::ENTRY_UNKNOWN) begin
      verdict = v_rev;
    end else begin
      verdict = ccc_pkg::ENTRY_NORMAL;
    end
  end

endmodule

FILE: src/congestion_classify_cache_unit.sv
// ----------------------------------------------------------------
// Congestion classify cache unit
// Classifies road lines as congested and caches per-line verdicts
// in a region-tagged store.
//
//   channel  direction  handshake            payload
//   in_*     input      in_valid / in_stall  query or refresh transaction
//   out_*    output     out_valid / out_stall congested, from_store
//   p*       config     APB, pready always 1 display, min speed, max class
//
// A transaction is accepted with a store read, then modify/write and
// result follow in S_LOOK. LINES not a power of two and below 65536 adds
// S_INDEX for the index reduction. A refresh or region change with a dirty
// store first runs a clear sweep of one store entry per cycle, then S_DONE
// finishes once the result slot is free. After reset a clear sweep of
// every store entry runs before the first accept. A stalled result holds
// the finished transaction until the slot frees.
// ----------------------------------------------------------------
`include "assert_macros.svh"

module congestion_classify_cache_unit #(
  parameter int unsigned LINES      = ccc_pkg::LINES_DEF,
  parameter int unsigned SPEED_BITS = ccc_pkg::SPEED_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_action,
  input  logic [ccc_pkg::REGION_BITS-1:0]       in_region_code,
  input  logic                                  in_region_ready,
  input  logic [ccc_pkg::LINE_BITS-1:0]         in_line_index,
  input  logic [ccc_pkg::CLASS_BITS-1:0]        in_road_class,
  input  logic [ccc_pkg::LAYER_BITS-1:0]        in_pen_layer,
  input  logic [SPEED_BITS-1:0]                 in_speed_forward,
  input  logic [SPEED_BITS-1:0]                 in_average_forward,
  input  logic [SPEED_BITS-1:0]                 in_speed_reverse,
  input  logic [SPEED_BITS-1:0]                 in_average_reverse,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_congested,
  output logic                                  out_from_store,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ccc_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [ccc_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [ccc_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                  pready
);

  localparam int AW = $clog2(LINES);
  localparam bit IDX_DIRECT = (LINES >= 65536) || ((LINES & (LINES - 1)) == 0);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / LINES);

  ccc_pkg::cfg_t   cfg;
  ccc_pkg::state_t state_r, state_nxt;

  // transaction registers
  logic                               action_r;
  logic [ccc_pkg::REGION_BITS-1:0]    region_r;
  logic                               ready_r;
  logic [ccc_pkg::CLASS_BITS-1:0]     class_r;
  logic [ccc_pkg::LAYER_BITS-1:0]     layer_r;
  logic [SPEED_BITS-1:0]              spd_fwd_r, avg_fwd_r, spd_rev_r, avg_rev_r;
  logic [ccc_pkg::LINE_BITS-1:0]      line_r;
  logic [ccc_pkg::LINE_BITS-1:0]      q_r;
  logic [AW-1:0]                      idx_r, idx_nxt;
  ccc_pkg::entry_t                    entry_r, entry_nxt;

  // control registers
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_congested_r, out_from_store_r;
  logic                               dirty_r, dirty_nxt;
  logic                               pend_r, pend_nxt;
  logic                               held_valid_r, held_valid_nxt;
  logic [ccc_pkg::REGION_BITS-1:0]    held_region_r, held_region_nxt;
  logic [AW-1:0]                      sweep_r, sweep_nxt;

  // store port
  logic                               store_rd_en, store_wr_en;
  logic [AW-1:0]                      store_rd_addr, store_wr_addr;
  ccc_pkg::entry_t                    store_rd_data, store_wr_data;

  logic                               in_accept;
  logic                               out_free;
  logic                               sweep_last;
  logic [AW-1:0]                      idx_direct, idx_mod;
  logic [47:0]                        q_prod;
  logic [31:0]                        rem, rem_fix;
  logic                               bypass, lookup, retag, clear_needed;
  ccc_pkg::entry_t                    entry_look, entry_sel, verdict;
  logic                               finish;
  logic                               fin_wr, fin_congested, fin_store;
  ccc_pkg::entry_t                    fin_wdata;

  ccc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccc_store #(
    .LINES (LINES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (store_rd_en),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data),
    .wr_en   (store_wr_en),
    .wr_addr (store_wr_addr),
    .wr_data (store_wr_data)
  );

  ccc_judge #(
    .SPEED_BITS (SPEED_BITS)
  ) u_judge (
    .cfg             (cfg),
    .speed_forward   (spd_fwd_r),
    .average_forward (avg_fwd_r),
    .speed_reverse   (spd_rev_r),
    .average_reverse (avg_rev_r),
    .verdict         (verdict)
  );

  assign in_stall  = (state_r != ccc_pkg::S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign sweep_last = (sweep_r == AW'(LINES - 1));

  // line index reduction
  assign idx_direct = AW'(in_line_index);
  assign q_prod     = 48'(in_line_index) * 48'(RECIP);
  assign rem        = 32'(line_r) - (32'(q_r) * 32'(LINES));
  assign rem_fix    = (rem >= 32'(LINES)) ? (rem - 32'(LINES)) : rem;
  assign idx_mod    = AW'(rem_fix);

  // transaction classification
  assign bypass = ~cfg.display_enabled | (layer_r > ccc_pkg::LAYER_MAX) |
                  (class_r > cfg.max_road_class);
  assign lookup = ~action_r & ~bypass & ready_r;
  assign retag  = ~held_valid_r | (held_region_r != region_r);
  assign clear_needed = (action_r | (lookup & retag)) & dirty_r;
  assign entry_look = clear_needed ? ccc_pkg::ENTRY_UNKNOWN : store_rd_data;
  assign entry_sel  = (state_r == ccc_pkg::S_LOOK) ? entry_look : entry_r;

  always_comb begin
    fin_wr        = 1'b0;
    fin_congested = 1'b0;
    fin_store     = 1'b0;
    fin_wdata     = entry_sel;
    priority if (action_r || bypass) begin
      fin_wr = 1'b0;
    end else if (!ready_r) begin
      fin_wr    = 1'b1;
      fin_wdata = entry_sel | ccc_pkg::ENTRY_NORMAL;
    end else if (entry_sel == ccc_pkg::ENTRY_NORMAL) begin
      fin_store = 1'b1;
    end else if (entry_sel == ccc_pkg::ENTRY_CONGESTED) begin
      fin_congested = 1'b1;
      fin_store     = 1'b1;
    end else begin
      fin_wr        = 1'b1;
      fin_wdata     = entry_sel | verdict;
      fin_congested = (verdict == ccc_pkg::ENTRY_CONGESTED);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    entry_nxt       = entry_r;
    dirty_nxt       = dirty_r;
    pend_nxt        = pend_r;
    held_valid_nxt  = held_valid_r;
    held_region_nxt = held_region_r;
    sweep_nxt       = sweep_r;
    store_rd_en     = 1'b0;
    store_rd_addr   = idx_direct;
    store_wr_en     = 1'b0;
    store_wr_addr   = idx_r;
    store_wr_data   = fin_wdata;
    finish          = 1'b0;

    unique case (state_r)
      ccc_pkg::S_SWEEP: begin
        store_wr_en   = 1'b1;
        store_wr_addr = sweep_r;
        store_wr_data = ccc_pkg::ENTRY_UNKNOWN;
        sweep_nxt     = sweep_r + AW'(1);
        if (sweep_last) begin
          sweep_nxt = '0;
          dirty_nxt = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? ccc_pkg::S_DONE : ccc_pkg::S_IDLE;
        end
      end
      ccc_pkg::S_IDLE: begin
        if (in_valid) begin
          if (IDX_DIRECT) begin
            store_rd_en   = 1'b1;
            store_rd_addr = idx_direct;
            idx_nxt       = idx_direct;
            state_nxt     = ccc_pkg::S_LOOK;
          end else begin
            state_nxt     = ccc_pkg::S_INDEX;
          end
        end
      end
      ccc_pkg::S_INDEX: begin
        store_rd_en   = 1'b1;
        store_rd_addr = idx_mod;
        idx_nxt       = idx_mod;
        state_nxt     = ccc_pkg::S_LOOK;
      end
      ccc_pkg::S_LOOK: begin
        if (action_r) begin
          held_valid_nxt = 1'b0;
        end else if (lookup && retag) begin
          held_valid_nxt  = 1'b1;
          held_region_nxt = region_r;
        end
        if (clear_needed) begin
          entry_nxt = ccc_pkg::ENTRY_UNKNOWN;
          pend_nxt  = 1'b1;
          state_nxt = ccc_pkg::S_SWEEP;
        end else if (out_free) begin
          finish    = 1'b1;
          state_nxt = ccc_pkg::S_IDLE;
        end else begin
          entry_nxt = entry_look;
          state_nxt = ccc_pkg::S_DONE;
        end
      end
      ccc_pkg::S_DONE: begin
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = ccc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ccc_pkg::S_IDLE;
      end
    endcase

    if (finish && fin_wr) begin
      store_wr_en   = 1'b1;
      store_wr_addr = idx_r;
      store_wr_data = fin_wdata;
      dirty_nxt     = 1'b1;
    end
  end

  assign out_valid_nxt = finish | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ccc_pkg::S_SWEEP;
      out_valid_r   <= 1'b0;
      dirty_r       <= 1'b0;
      pend_r        <= 1'b0;
      held_valid_r  <= 1'b0;
      held_region_r <= '0;
      sweep_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      dirty_r       <= dirty_nxt;
      pend_r        <= pend_nxt;
      held_valid_r  <= held_valid_nxt;
      held_region_r <= held_region_nxt;
      sweep_r       <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    entry_r <= entry_nxt;
    if (in_accept) begin
      action_r  <= in_action;
      region_r  <= in_region_code;
      ready_r   <= in_region_ready;
      class_r   <= in_road_class;
      layer_r   <= in_pen_layer;
      spd_fwd_r <= in_speed_forward;
      avg_fwd_r <= in_average_forward;
      spd_rev_r <= in_speed_reverse;
      avg_rev_r <= in_average_reverse;
      line_r    <= in_line_index;
      q_r       <= q_prod[47:32];
    end
    if (finish) begin
      out_congested_r  <= fin_congested;
      out_from_store_r <= fin_store;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_congested  = out_congested_r;
  assign out_from_store = out_from_store_r;

  `CCC_ASSERT_NEVER(a_no_rw_overlap, clk, rst_n, store_rd_en && store_wr_en, "store read and write overlap")
  `CCC_ASSERT(a_finish_slot_free, clk, rst_n, finish |-> out_free, "result register overwritten")
  `CCC_ASSERT(a_sweep_cleans, clk, rst_n, (state_r == ccc_pkg::S_SWEEP && sweep_last) |=> !dirty_r, "store dirty after clear sweep")

endmodule
